>>> design/mevt_pkg.sv
// ----------------------------------------------------------------------------
// mevt_pkg
// shared types, codes and constants of the midi event translator
// ----------------------------------------------------------------------------
`default_nettype none

package mevt_pkg;

    // received byte classes
    localparam logic [6:0] VALUE_MAX  = 7'h6F;
    localparam logic [6:0] BYTE_TICK  = 7'h7F;
    localparam logic [6:0] BYTE_STOP  = 7'h7E;
    localparam logic [6:0] BYTE_START = 7'h7D;
    localparam logic [6:0] CMD_BASE   = 7'h70;

    // command index ranges
    localparam logic [3:0] CMD_CC_FIRST   = 4'd4;
    localparam logic [3:0] CMD_PROG_FIRST = 4'd8;
    localparam logic [3:0] CMD_NONE_FIRST = 4'd12;

    // midi status bytes
    localparam logic [7:0] ST_STOP     = 8'hFC;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_PROG     = 8'hC0;

    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
    localparam logic [6:0] CC_ALL_VALUE     = 7'h7F;
    localparam logic [2:0] CC_SEL_NONE      = 3'd7;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    localparam logic [6:0] VELOCITY_RESET = 7'd100;
    localparam int unsigned NUM_CH         = 4;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        OP_STOP,
        OP_START,
        OP_NOTE,
        OP_CC,
        OP_PROG
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] ch;
        logic [6:0] val;
    } t_job;

    function automatic logic [6:0] cc_number(input logic [2:0] sel);
        logic [6:0] num;
        case (sel)
            3'd0:    num = 7'd1;
            3'd1:    num = 7'd2;
            3'd2:    num = 7'd3;
            3'd3:    num = 7'd7;
            3'd4:    num = 7'd10;
            3'd5:    num = 7'd11;
            3'd6:    num = 7'd12;
            default: num = 7'd0;
        endcase
        return num;
    endfunction

endpackage

`default_nettype wire

>>> design/mevt_if.sv
// ----------------------------------------------------------------------------
// mevt_if
// valid/ready channels of the midi event translator
// ----------------------------------------------------------------------------
`default_nettype none

interface mevt_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mevt_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] note_velocity;
    modport source (output valid, output note_velocity, input ready);
    modport sink   (input valid, input note_velocity, output ready);
endinterface

interface mevt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [1:0] byte_count;
    logic       last_of_run;
    modport source (output valid, output status_byte, output data_one, output data_two,
                    output byte_count, output last_of_run, input ready);
    modport sink   (input valid, input status_byte, input data_one, input data_two,
                    input byte_count, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> design/mevt_front.sv
// ----------------------------------------------------------------------------
// mevt_front
// accepts received bytes, tracks the latched command, issues jobs
// ----------------------------------------------------------------------------
`default_nettype none

module mevt_front (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mevt_in_if.sink       i_rx,
    output mevt_pkg::t_job o_job,
    output logic          o_job_valid,
    input  wire           i_job_ready
);
    import mevt_pkg::*;

    logic       r_pending, n_pending;
    logic [3:0] r_cmd, n_cmd;
    logic       accept;
    logic [6:0] b;

    assign i_rx.ready = i_job_ready;
    assign accept     = i_rx.valid && i_job_ready;
    assign b          = i_rx.rx_byte;

    always_comb begin
        n_pending   = r_pending;
        n_cmd       = r_cmd;
        o_job.op    = OP_START;
        o_job.ch    = r_cmd[1:0];
        o_job.val   = b;
        o_job_valid = 1'b0;
        if (b > VALUE_MAX) begin
            if (b == BYTE_STOP) begin
                o_job.op    = OP_STOP;
                o_job_valid = i_rx.valid;
            end else if (b == BYTE_START) begin
                o_job.op    = OP_START;
                o_job_valid = i_rx.valid;
            end else if (b != BYTE_TICK) begin
                n_cmd     = 4'(b - CMD_BASE);
                n_pending = 1'b1;
            end
        end else if (r_pending) begin
            n_pending = 1'b0;
            if (r_cmd < CMD_CC_FIRST) begin
                o_job.op    = OP_NOTE;
                o_job_valid = i_rx.valid;
            end else if (r_cmd < CMD_PROG_FIRST) begin
                o_job.op    = OP_CC;
                o_job_valid = i_rx.valid && (b[6:4] != CC_SEL_NONE);
            end else if (r_cmd < CMD_NONE_FIRST) begin
                o_job.op    = OP_PROG;
                o_job_valid = i_rx.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_cmd     <= 4'd0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_cmd     <= n_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/mevt_queue.sv
// ----------------------------------------------------------------------------
// mevt_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mevt_queue #(
    parameter int unsigned DEPTH = mevt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  mevt_pkg::t_job i_push_job,
    input  wire            i_push_valid,
    output logic           o_push_ready,
    output mevt_pkg::t_job o_pop_job,
    output logic           o_pop_valid,
    input  wire            i_pop_ready
);
    import mevt_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

>>> design/mevt_back.sv
// ----------------------------------------------------------------------------
// mevt_back
// carries out jobs one message per cycle while the output is not stalled, keeps notes and velocity
// ----------------------------------------------------------------------------
`default_nettype none

module mevt_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  mevt_pkg::t_job i_job,
    input  wire            i_job_valid,
    output logic           o_job_ready,
    mevt_cfg_if.sink       i_cfg,
    mevt_out_if.source     o_msg
);
    import mevt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STOP_FC,
        S_STOP_OFF,
        S_STOP_CC,
        S_NOTE_OFF,
        S_NOTE_ON,
        S_START,
        S_CC,
        S_PROG
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_ch, n_ch;
    logic [6:0] r_val, n_val;
    logic [6:0] r_notes [NUM_CH];
    logic [6:0] n_notes [NUM_CH];
    logic [6:0] r_velocity, n_velocity;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_status, n_status;
    logic [6:0] r_d1, n_d1;
    logic [6:0] r_d2, n_d2;
    logic [1:0] r_cnt, n_cnt;
    logic       r_last, n_last;
    logic       emit_ok;
    logic [1:0] ch_next;

    assign o_job_ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign emit_ok           = !r_out_valid || o_msg.ready;
    assign ch_next           = r_ch + 2'd1;
    assign o_msg.valid       = r_out_valid;
    assign o_msg.status_byte = r_status;
    assign o_msg.data_one    = r_d1;
    assign o_msg.data_two    = r_d2;
    assign o_msg.byte_count  = r_cnt;
    assign o_msg.last_of_run = r_last;

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_val       = r_val;
        n_notes     = r_notes;
        n_velocity  = i_cfg.valid ? i_cfg.note_velocity : r_velocity;
        n_out_valid = r_out_valid && !o_msg.ready;
        n_status    = r_status;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_cnt       = r_cnt;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_ch  = i_job.ch;
                    n_val = i_job.val;
                    case (i_job.op)
                        OP_STOP:  n_state = S_STOP_FC;
                        OP_START: n_state = S_START;
                        OP_NOTE:  n_state = ((i_job.val == '0) || (r_notes[i_job.ch] != '0))
                                            ? S_NOTE_OFF : S_NOTE_ON;
                        OP_CC:    n_state = S_CC;
                        OP_PROG:  n_state = S_PROG;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_STOP_FC: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_STOP;
                    n_d1        = '0;
                    n_d2        = '0;
                    n_cnt       = LEN_ONE;
                    n_last      = 1'b0;
                    n_ch        = 2'd0;
                    n_state     = (r_notes[0] != '0) ? S_STOP_OFF : S_STOP_CC;
                end
            end
            S_STOP_OFF: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_NOTE_OFF | {6'd0, r_ch};
                    n_d1        = r_notes[r_ch];
                    n_d2        = r_velocity;
                    n_cnt       = LEN_THREE;
                    n_last      = 1'b0;
                    n_state     = S_STOP_CC;
                end
            end
            S_STOP_CC: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_CTRL | {6'd0, r_ch};
                    n_d1        = CC_ALL_NOTES_OFF;
                    n_d2        = CC_ALL_VALUE;
                    n_cnt       = LEN_THREE;
                    n_last      = (r_ch == 2'd3);
                    n_ch        = ch_next;
                    if (r_ch == 2'd3) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = (r_notes[ch_next] != '0) ? S_STOP_OFF : S_STOP_CC;
                    end
                end
            end
            S_NOTE_OFF: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_NOTE_OFF | {6'd0, r_ch};
                    n_d1        = r_notes[r_ch];
                    n_d2        = r_velocity;
                    n_cnt       = LEN_THREE;
                    n_last      = (r_val == '0);
                    if (r_val == '0) begin
                        n_notes[r_ch] = '0;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_NOTE_ON;
                    end
                end
            end
            S_NOTE_ON: begin
                if (emit_ok) begin
                    n_out_valid   = 1'b1;
                    n_status      = ST_NOTE_ON | {6'd0, r_ch};
                    n_d1          = r_val;
                    n_d2          = r_velocity;
                    n_cnt         = LEN_THREE;
                    n_last        = 1'b1;
                    n_notes[r_ch] = r_val;
                    n_state       = S_IDLE;
                end
            end
            S_START: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_START;
                    n_d1        = '0;
                    n_d2        = '0;
                    n_cnt       = LEN_ONE;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_CC: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_CTRL | {6'd0, r_ch};
                    n_d1        = cc_number(r_val[6:4]);
                    n_d2        = {r_val[3:0], 3'b000};
                    n_cnt       = LEN_THREE;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_PROG: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_PROG | {6'd0, r_ch};
                    n_d1        = r_val;
                    n_d2        = '0;
                    n_cnt       = LEN_TWO;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_velocity  <= VELOCITY_RESET;
            for (int i = 0; i < NUM_CH; i++) begin
                r_notes[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_velocity  <= n_velocity;
            r_notes     <= n_notes;
        end
        r_ch     <= n_ch;
        r_val    <= n_val;
        r_status <= n_status;
        r_d1     <= n_d1;
        r_d2     <= n_d2;
        r_cnt    <= n_cnt;
        r_last   <= n_last;
    end

endmodule

`default_nettype wire

>>> design/midi_event_translator.sv
// ----------------------------------------------------------------------------
// midi_event_translator
// turns 7-bit command/value bytes from a serial link into midi messages
// ----------------------------------------------------------------------------
// i_rx carries one received byte per item; o_msg carries one midi message
// per item, last_of_run marking the final message caused by a byte. i_cfg
// writes note_velocity (reset value 100); the user writes it only while the
// block is idle, which the block itself does not enforce. the front takes
// a byte every cycle while the job queue has room and updates the latched
// command at once; bytes that cause messages become jobs. the back pops a
// job, then emits one message per cycle while the receiver takes them into
// a registered output stage; its message sequencer sets the rate. a byte's
// first message passes the queue, the back's state and output registers.
// a stalled receiver holds the output register and the back; the queue
// then fills and i_rx.ready drops. reset clears the latched command, the
// remembered notes, the queue and the output valid, and restores velocity.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_event_translator #(
    parameter int unsigned QUEUE_DEPTH = mevt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mevt_in_if.sink     i_rx,
    mevt_cfg_if.sink    i_cfg,
    mevt_out_if.source  o_msg
);
    import mevt_pkg::*;

    // front to queue
    t_job push_job;
    logic push_valid;
    logic push_ready;

    // queue to back
    t_job pop_job;
    logic pop_valid;
    logic pop_ready;

    mevt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .o_job       (push_job),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready)
    );

    mevt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_job   (push_job),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_pop_job    (pop_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready)
    );

    // back: message sequencer with registered output stage
    mevt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (pop_job),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_cfg       (i_cfg),
        .o_msg       (o_msg)
    );

endmodule

`default_nettype wire
